// File: src/swdf_pkg.sv
package swdf_pkg;

  localparam int HDR_BYTES = 10;
  localparam logic [3:0] HDR_LAST = 4'(HDR_BYTES - 1);

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_RESYNC  = 2'd2;

  localparam logic REG_SYNC_WORD = 1'b0;
  localparam logic REG_MAX_SLIPS = 1'b1;

  localparam logic [7:0] MAX_SLIPS_RST = 8'd10;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] msg_type;
    logic [31:0] payload_length;
    logic [7:0]  payload_byte;
    logic        last;
  } res_t;

endpackage

// File: src/swdf_front.sv
module swdf_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          rx_byte,
  input  logic [31:0]         sync_word,
  input  logic [7:0]          max_slips,
  output logic                res_valid,
  output swdf_pkg::res_t      res
);

  logic [7:0]  win_r   [swdf_pkg::HDR_BYTES];
  logic [7:0]  win_nxt [swdf_pkg::HDR_BYTES];
  logic [3:0]  fill_r, fill_nxt;
  logic        in_pay_r, in_pay_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [15:0] type_r, type_nxt;
  logic [31:0] len_r, len_nxt;
  logic [7:0]  slip_r, slip_nxt;
  logic [31:0] head;
  logic        win_full;

  assign head     = {win_r[0], win_r[1], win_r[2], win_r[3]};
  assign win_full = (fill_r == swdf_pkg::HDR_LAST);

  always_comb begin
    win_nxt    = win_r;
    fill_nxt   = fill_r;
    in_pay_nxt = in_pay_r;
    rem_nxt    = rem_r;
    type_nxt   = type_r;
    len_nxt    = len_r;
    slip_nxt   = slip_r;
    res_valid  = 1'b0;
    res        = '0;
    if (accept) begin
      if (in_pay_r) begin
        res_valid          = 1'b1;
        res.kind           = swdf_pkg::KIND_PAYLOAD;
        res.msg_type       = type_r;
        res.payload_length = len_r;
        res.payload_byte   = rx_byte;
        res.last           = (rem_r <= 32'd1);
        if (rem_r != 32'd0) begin
          rem_nxt = rem_r - 32'd1;
        end
        if (rem_r <= 32'd1) begin
          in_pay_nxt = 1'b0;
        end
      end else if (!win_full) begin
        for (int i = 0; i < swdf_pkg::HDR_BYTES; i++) begin
          if (fill_r == 4'(i)) begin
            win_nxt[i] = rx_byte;
          end
        end
        fill_nxt = fill_r + 4'd1;
      end else if (head != sync_word) begin
        if (slip_r < max_slips) begin
          // drop the oldest byte, keep the window one short of full
          slip_nxt = slip_r + 8'd1;
          for (int i = 0; i < swdf_pkg::HDR_BYTES - 2; i++) begin
            win_nxt[i] = win_r[i+1];
          end
          win_nxt[swdf_pkg::HDR_BYTES-2] = rx_byte;
          win_nxt[swdf_pkg::HDR_BYTES-1] = 8'd0;
          fill_nxt = swdf_pkg::HDR_LAST;
        end else begin
          slip_nxt  = 8'd0;
          fill_nxt  = 4'd0;
          res_valid = 1'b1;
          res.kind  = swdf_pkg::KIND_RESYNC;
        end
      end else begin
        slip_nxt           = 8'd0;
        fill_nxt           = 4'd0;
        type_nxt           = {win_r[4], win_r[5]};
        len_nxt            = {win_r[6], win_r[7], win_r[8], rx_byte};
        res_valid          = 1'b1;
        res.kind           = swdf_pkg::KIND_HEADER;
        res.msg_type       = {win_r[4], win_r[5]};
        res.payload_length = {win_r[6], win_r[7], win_r[8], rx_byte};
        if ({win_r[6], win_r[7], win_r[8], rx_byte} == 32'd0) begin
          res.last = 1'b1;
        end else begin
          in_pay_nxt = 1'b1;
          rem_nxt    = {win_r[6], win_r[7], win_r[8], rx_byte};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    if (!rst_n) begin
      fill_r   <= 4'd0;
      in_pay_r <= 1'b0;
      rem_r    <= 32'd0;
      type_r   <= 16'd0;
      len_r    <= 32'd0;
      slip_r   <= 8'd0;
    end else begin
      fill_r   <= fill_nxt;
      in_pay_r <= in_pay_nxt;
      rem_r    <= rem_nxt;
      type_r   <= type_nxt;
      len_r    <= len_nxt;
      slip_r   <= slip_nxt;
    end
  end

`ifndef SYNTH
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= swdf_pkg::HDR_LAST)
    else $error("header fill out of range");

  a_pay_rem: assert property (@(posedge clk) disable iff (!rst_n)
    in_pay_r |-> (rem_r != 32'd0))
    else $error("payload active with no bytes remaining");
`endif

endmodule

// File: src/swdf_queue.sv
module swdf_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  swdf_pkg::res_t push_data,
  input  logic           pop,
  output swdf_pkg::res_t pop_data,
  output logic           empty,
  output logic           full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  swdf_pkg::res_t mem_r [DEPTH];
  logic [PW-1:0]  wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  assign empty    = (cnt_r == CW'(0));
  assign full     = (cnt_r == CW'(DEPTH));
  assign pop_data = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PW'(DEPTH - 1)) ? PW'(0) : wr_r + PW'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == PW'(DEPTH - 1)) ? PW'(0) : rd_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue pop while empty");

  a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + CW'(1)))
    else $error("queue count did not advance");
`endif

endmodule

// File: src/swdf_back.sv
module swdf_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  swdf_pkg::res_t q_data,
  output logic           q_pop,
  input  logic           out_stall,
  output logic           out_valid,
  output swdf_pkg::res_t out_res
);

  logic           vld_r, vld_nxt;
  swdf_pkg::res_t res_r;

  assign q_pop     = !q_empty && (!vld_r || !out_stall);
  assign vld_nxt   = q_pop ? 1'b1 : (vld_r && out_stall);
  assign out_valid = vld_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= q_data;
    end
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

endmodule

// File: src/sync_word_length_frame_deframer_unit.sv
// Path: an accepted byte's result goes into the result queue, then into the output register, then out_*.
// Throughput: one byte per cycle while in_stall is low; the front decodes a header or payload byte each time.
// A QUEUE_DEPTH-entry (four by default) result queue sits between the decoder and the output register.
// Reset (rst_n low, synchronous) empties the header window, queue and output stage,
// clears the slip count and payload state, sets sync_word to 0 and max_slips to 10.
module sync_word_length_frame_deframer_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [15:0] out_msg_type,
  output logic [31:0] out_payload_length,
  output logic [7:0]  out_payload_byte,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0]    sync_r;
  logic [7:0]     slips_r;
  logic           cfg_wr;
  logic           accept;
  logic           res_valid;
  swdf_pkg::res_t res;
  logic           q_empty, q_full, q_pop;
  swdf_pkg::res_t q_data, out_res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == swdf_pkg::REG_MAX_SLIPS) ? {24'd0, slips_r} : sync_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r  <= 32'd0;
      slips_r <= swdf_pkg::MAX_SLIPS_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == swdf_pkg::REG_SYNC_WORD) begin
        sync_r <= pwdata;
      end else begin
        slips_r <= pwdata[7:0];
      end
    end
  end

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  swdf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .rx_byte   (in_rx_byte),
    .sync_word (sync_r),
    .max_slips (slips_r),
    .res_valid (res_valid),
    .res       (res)
  );

  swdf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty),
    .full      (q_full)
  );

  swdf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_kind           = out_res.kind;
  assign out_msg_type       = out_res.msg_type;
  assign out_payload_length = out_res.payload_length;
  assign out_payload_byte   = out_res.payload_byte;
  assign out_last           = out_res.last;

endmodule

// File: tb/sv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_PAD = 8;
  localparam int SEGMENT_WORDS = 265;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_op_t;

  typedef struct packed {
    row_op_t         op;
    logic            sel;
    logic [31:0]     value;
    logic [7:0]      rx;
    bit              known;
    swdf_pkg::res_t  want;
  } plan_row_t;

  localparam swdf_pkg::res_t NO_RES = '0;

  localparam plan_row_t PLAN [36] = '{
    '{ROW_CFG,  swdf_pkg::REG_SYNC_WORD, 32'h0000_0000, 8'h00, 1'b0, NO_RES},
    '{ROW_BYTE, swdf_pkg::REG_SYNC_WORD, 32'h0, 8'h00, 1'b0, NO_RES},
    '{ROW_BYTE, swdf_pkg::REG_SYNC_WORD, 32'h0, 8'h00, 1'b0, NO_RES},
    '{ROW_BYTE, swdf_pkg::REG_SYNC_WORD, 32'h0, 8'h00, 1'b0, NO_RES},
    '{ROW_BYTE, swdf_pkg::REG_SYNC_WORD, 32'h0, 8'h00, 1'b0, NO_RES},
    '{ROW_BYTE, swdf_pkg::REG_SYNC_WORD, 32'h0, 8'h00, 1'b0, NO_RES},
    '{ROW_BYTE, swdf_pkg::REG_SYNC_WORD, 32'h0, 8'h00, 1'b0, NO_RES},
    '{ROW_BYTE, swdf_pkg::REG_SYNC_WORD, 32'h0, 8'h00, 1'b0, NO_RES},
    '{ROW_BYTE, swdf_pkg::REG_SYNC_WORD, 32'h0, 8'h00, 1'b0, NO_RES},
    '{ROW_BYTE, swdf_pkg::REG_SYNC_WORD, 32'h0, 8'h00, 1'b0, NO_RES},
    '{ROW_BYTE, swdf_pkg::REG_SYNC_WORD, 32'h0, 8'h00, 1'b1,
      '{swdf_pkg::KIND_HEADER, 16'h0000, 32'h0000_0000, 8'h00, 1'b1}},
    '{ROW_CFG,  swdf_pkg::REG_SYNC_WORD, 32'hFFFF_FFFF, 8'h00, 1'b0, NO_RES},
    '{ROW_CFG,  swdf_pkg::REG_MAX_SLIPS, 32'h0000_0001, 8'h00, 1'b0, NO_RES},
    '{ROW_BYTE, swdf_pkg::REG_SYNC_WORD, 32'h0, 8'h01, 1'b0, NO_RES},
    '{ROW_BYTE, swdf_pkg::REG_SYNC_WORD, 32'h0, 8'hFF, 1'b0, NO_RES},
    '{ROW_BYTE, swdf_pkg::REG_SYNC_WORD, 32'h0, 8'hFF, 1'b0, NO_RES},
    '{ROW_BYTE, swdf_pkg::REG_SYNC_WORD, 32'h0, 8'hFF, 1'b0, NO_RES},
    '{ROW_BYTE, swdf_pkg::REG_SYNC_WORD, 32'h0, 8'hFF, 1'b0, NO_RES},
    '{ROW_BYTE, swdf_pkg::REG_SYNC_WORD, 32'h0, 8'hFF, 1'b0, NO_RES},
    '{ROW_BYTE, swdf_pkg::REG_SYNC_WORD, 32'h0, 8'hFF, 1'b0, NO_RES},
    '{ROW_BYTE, swdf_pkg::REG_SYNC_WORD, 32'h0, 8'h00, 1'b0, NO_RES},
    '{ROW_BYTE, swdf_pkg::REG_SYNC_WORD, 32'h0, 8'h00, 1'b0, NO_RES},
    '{ROW_BYTE, swdf_pkg::REG_SYNC_WORD, 32'h0, 8'h00, 1'b0, NO_RES},
    '{ROW_BYTE, swdf_pkg::REG_SYNC_WORD, 32'h0, 8'h01, 1'b1,
      '{swdf_pkg::KIND_HEADER, 16'hFFFF, 32'h0000_0001, 8'h00, 1'b0}},
    '{ROW_BYTE, swdf_pkg::REG_SYNC_WORD, 32'h0, 8'hFF, 1'b1,
      '{swdf_pkg::KIND_PAYLOAD, 16'hFFFF, 32'h0000_0001, 8'hFF, 1'b1}},
    '{ROW_BYTE, swdf_pkg::REG_SYNC_WORD, 32'h0, 8'h00, 1'b0, NO_RES},
    '{ROW_BYTE, swdf_pkg::REG_SYNC_WORD, 32'h0, 8'h00, 1'b0, NO_RES},
    '{ROW_BYTE, swdf_pkg::REG_SYNC_WORD, 32'h0, 8'h00, 1'b0, NO_RES},
    '{ROW_BYTE, swdf_pkg::REG_SYNC_WORD, 32'h0, 8'h00, 1'b0, NO_RES},
    '{ROW_BYTE, swdf_pkg::REG_SYNC_WORD, 32'h0, 8'h00, 1'b0, NO_RES},
    '{ROW_BYTE, swdf_pkg::REG_SYNC_WORD, 32'h0, 8'h00, 1'b0, NO_RES},
    '{ROW_BYTE, swdf_pkg::REG_SYNC_WORD, 32'h0, 8'h00, 1'b0, NO_RES},
    '{ROW_BYTE, swdf_pkg::REG_SYNC_WORD, 32'h0, 8'h00, 1'b0, NO_RES},
    '{ROW_BYTE, swdf_pkg::REG_SYNC_WORD, 32'h0, 8'h00, 1'b0, NO_RES},
    '{ROW_BYTE, swdf_pkg::REG_SYNC_WORD, 32'h0, 8'h00, 1'b0, NO_RES},
    '{ROW_BYTE, swdf_pkg::REG_SYNC_WORD, 32'h0, 8'h00, 1'b1,
      '{swdf_pkg::KIND_RESYNC, 16'h0000, 32'h0000_0000, 8'h00, 1'b0}}
  };

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [15:0] out_msg_type;
  logic [31:0] out_payload_length;
  logic [7:0]  out_payload_byte;
  logic        out_last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  sync_word_length_frame_deframer_unit dut (.*);

  logic [31:0] sync_cfg = 32'h0;
  logic [7:0]  slip_cfg = swdf_pkg::MAX_SLIPS_RST;
  logic [7:0]  window [swdf_pkg::HDR_BYTES] = '{default: 8'h00};
  int          fill = 0;
  bit          in_pay = 1'b0;
  logic [31:0] remaining = 32'h0;
  logic [31:0] cur_len = 32'h0;
  logic [15:0] cur_type = 16'h0;
  logic [7:0]  slips = 8'h0;

  swdf_pkg::res_t decoded_due [$];
  int   mismatches = 0;
  int   bytes_fed = 0;
  int   send_idle_pct = 37;
  int   recv_stall_pct = 71;
  bit   hold_req = 1'b0;
  int   hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic deframe_byte(input logic [7:0] b, output bit got,
                              output swdf_pkg::res_t r);
    logic [31:0] head;
    got = 1'b0;
    r = NO_RES;
    if (in_pay) begin
      got = 1'b1;
      r = '{swdf_pkg::KIND_PAYLOAD, cur_type, cur_len, b, remaining <= 32'd1};
      if (remaining != 0) remaining--;
      if (remaining == 0) in_pay = 1'b0;
      return;
    end
    if (fill >= swdf_pkg::HDR_BYTES) fill = swdf_pkg::HDR_BYTES - 1;
    window[fill] = b;
    fill++;
    if (fill < swdf_pkg::HDR_BYTES) return;
    head = {window[0], window[1], window[2], window[3]};
    if (head != sync_cfg && slips < slip_cfg) begin
      slips++;
      for (int i = 0; i < swdf_pkg::HDR_BYTES - 1; i++) window[i] = window[i + 1];
      window[swdf_pkg::HDR_BYTES - 1] = 8'h00;
      fill = swdf_pkg::HDR_BYTES - 1;
      return;
    end
    got = 1'b1;
    if (head != sync_cfg) begin
      r.kind = swdf_pkg::KIND_RESYNC;
    end else begin
      cur_type = {window[4], window[5]};
      cur_len = {window[6], window[7], window[8], window[9]};
      r = '{swdf_pkg::KIND_HEADER, cur_type, cur_len, 8'h00, cur_len == 32'd0};
      in_pay = cur_len != 32'd0;
      remaining = cur_len;
    end
    slips = 8'h0;
    fill = 0;
    foreach (window[i]) window[i] = 8'h00;
  endtask

  task automatic send_byte(input logic [7:0] b, input bit known,
                           input swdf_pkg::res_t given);
    int             gap;
    bit             got;
    swdf_pkg::res_t r;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    deframe_byte(b, got, r);
    if (known) decoded_due.push_back(given);
    else if (got) decoded_due.push_back(r);
    bytes_fed++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (decoded_due.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic write_reg(input logic sel, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (sel == swdf_pkg::REG_SYNC_WORD) sync_cfg = value;
    else slip_cfg = value[7:0];
    @(posedge clk);
  endtask

  task automatic send_frame(input logic [31:0] flip, input logic [15:0] ty,
                            input logic [31:0] len, input int n_pay);
    logic [79:0] hdr;
    hdr = {sync_cfg ^ flip, ty, len};
    for (int i = 0; i < swdf_pkg::HDR_BYTES; i++)
      send_byte(hdr[79 - 8 * i -: 8], 1'b0, NO_RES);
    repeat (n_pay) send_byte(8'($urandom_range(255)), 1'b0, NO_RES);
  endtask

  // distinct bytes keep a marker from overlapping itself across a slip
  function automatic logic [31:0] fresh_sync();
    logic [31:0] s;
    do s = $urandom();
    while (s[31:24] == s[23:16] || s[31:24] == s[15:8] || s[31:24] == s[7:0] ||
           s[23:16] == s[15:8] || s[23:16] == s[7:0] || s[15:8] == s[7:0]);
    return s;
  endfunction

  task automatic run_segment(input int n_words);
    int stop;
    int pick;
    int len;
    stop = bytes_fed + n_words;
    while (bytes_fed < stop) begin
      pick = $urandom_range(99);
      len = ($urandom_range(9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
      if (pick < 75) begin
        if ($urandom_range(9) < 3)
          repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)), 1'b0, NO_RES);
        send_frame(32'h0, 16'($urandom()), 32'(len), len);
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 14)) send_byte(8'($urandom_range(255)), 1'b0, NO_RES);
      end else begin
        send_frame(32'h1 << $urandom_range(31), 16'($urandom()), 32'(len), len);
      end
    end
  endtask

  always @(posedge clk) begin
    swdf_pkg::res_t seen;
    swdf_pkg::res_t want;
    bit             bad;
    bad = 1'b0;
    if (rst_n && out_valid && !out_stall) begin
      seen = {out_kind, out_msg_type, out_payload_length, out_payload_byte, out_last};
      if (decoded_due.size() == 0) begin
        $error("unexpected word: kind %0d msg_type %0h", seen.kind, seen.msg_type);
        bad = 1'b1;
      end else begin
        want = decoded_due.pop_front();
        if (seen.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, seen.kind);
          bad = 1'b1;
        end
        if (seen.msg_type !== want.msg_type) begin
          $error("msg_type: expected %0h, got %0h", want.msg_type, seen.msg_type);
          bad = 1'b1;
        end
        if (seen.payload_length !== want.payload_length) begin
          $error("payload_length: expected %0h, got %0h", want.payload_length,
                 seen.payload_length);
          bad = 1'b1;
        end
        if (seen.payload_byte !== want.payload_byte) begin
          $error("payload_byte: expected %0h, got %0h", want.payload_byte, seen.payload_byte);
          bad = 1'b1;
        end
        if (seen.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, seen.last);
          bad = 1'b1;
        end
      end
    end
    if (bad) mismatches++;
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) quiet = 0;
      else quiet++;
    end
    $display("testbench failed");
    $finish;
  end

  initial begin
    logic [7:0] slip_limit;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    foreach (PLAN[i]) begin
      if (PLAN[i].op == ROW_CFG) begin
        settle();
        write_reg(PLAN[i].sel, PLAN[i].value);
      end else begin
        send_byte(PLAN[i].rx, PLAN[i].known, PLAN[i].want);
      end
    end
    for (int seg = 0; seg < 6; seg++) begin
      settle();
      send_idle_pct = (seg < 2) ? 37 : (seg < 4) ? 71 : 0;
      recv_stall_pct = (seg < 2) ? 71 : (seg < 4) ? 37 : 0;
      case (seg)
        0: slip_limit = 8'd3;
        1: slip_limit = 8'd0;
        2: slip_limit = 8'd255;
        3: slip_limit = 8'd1;
        4: slip_limit = 8'($urandom_range(2, 30));
        default: slip_limit = swdf_pkg::MAX_SLIPS_RST;
      endcase
      write_reg(swdf_pkg::REG_SYNC_WORD, fresh_sync());
      write_reg(swdf_pkg::REG_MAX_SLIPS, 32'(slip_limit));
      // hold the output long enough to back up the result queue
      if (seg == 0 || seg == 4) hold_req = 1'b1;
      run_segment(SEGMENT_WORDS);
    end
    settle();
    write_reg(swdf_pkg::REG_MAX_SLIPS, 32'd255);
    send_frame(32'h0, 16'($urandom()), 32'hFFFF_FFFF, 20);
    settle();
    if (mismatches == 0 && decoded_due.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// File: files.f
src/swdf_pkg.sv
src/swdf_front.sv
src/swdf_queue.sv
src/swdf_back.sv
src/sync_word_length_frame_deframer_unit.sv
tb/sv/testbench.sv
